[hdl/sbd_pkg.sv]
// sbd_pkg: shared types and constants of the serial-bus channel decoder.
// No dependencies; imported by every module under hdl/.
package sbd_pkg;

  localparam logic [7:0] SYNC_BYTE      = 8'h0F;
  localparam logic [4:0] NUM_CHANNELS   = 5'd16;
  localparam logic [4:0] FRAME_BYTES    = 5'd25;
  localparam logic [4:0] LAST_DATA_BYTE = 5'd22;
  localparam logic [4:0] RAW_BITS       = 5'd11;
  localparam logic [4:0] BITS_PER_BYTE  = 5'd8;
  localparam logic [3:0] MAX_BITS_HELD  = 4'd10;

  localparam int BUF_W = 18;
  localparam int RAW_W = 11;

  localparam logic [10:0] CENTER_RESET  = 11'd1024;
  localparam logic [10:0] DEADBAND_RESET = 11'd20;
  localparam logic [4:0]  DB_CHAN_RESET  = 5'd4;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CENTER   = 2'd0,
    CFG_DEADBAND = 2'd1,
    CFG_DB_CHANS = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0] center_value;
    logic [10:0] deadband;
    logic [4:0]  deadband_channels;
  } cfg_t;

  // one completed raw channel from the unpacker
  typedef struct packed {
    logic             fire;
    logic [3:0]       chan;
    logic [RAW_W-1:0] raw;
    logic             last;
  } chan_res_t;

endpackage

[hdl/sbd_unpack.sv]
// sbd_unpack: frame tracking and LSB-first bit packing of data bytes into
// 11-bit raw channels. Depends on sbd_pkg.
module sbd_unpack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [7:0]         rx_byte,
  input  logic               frame_first,
  output sbd_pkg::chan_res_t res
);
  import sbd_pkg::*;

  logic [4:0]       byte_pos_r, byte_pos_nxt;
  logic             frame_ok_r, frame_ok_nxt;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [4:0]       held_r, held_nxt;
  logic [4:0]       next_ch_r, next_ch_nxt;

  logic [BUF_W-1:0] merged;
  logic [4:0]       held_sum;
  logic             take;

  always_comb begin
    merged   = buf_r | (BUF_W'(rx_byte) << held_r[3:0]);
    held_sum = held_r + BITS_PER_BYTE;
    take     = frame_ok_r && (byte_pos_r >= 5'd1) && (byte_pos_r <= LAST_DATA_BYTE) &&
               (next_ch_r < NUM_CHANNELS);

    byte_pos_nxt = byte_pos_r;
    frame_ok_nxt = frame_ok_r;
    buf_nxt      = buf_r;
    held_nxt     = held_r;
    next_ch_nxt  = next_ch_r;
    // fire tells whether the presented byte completes a channel, independent of go
    res.fire     = !frame_first && take && (held_sum >= RAW_BITS);
    res.chan     = next_ch_r[3:0];
    res.raw      = merged[RAW_W-1:0];
    res.last     = (next_ch_r == NUM_CHANNELS - 5'd1);

    if (go) begin
      if (frame_first) begin
        // restart: drop any partial frame
        frame_ok_nxt = (rx_byte == SYNC_BYTE);
        buf_nxt      = '0;
        held_nxt     = '0;
        next_ch_nxt  = '0;
        byte_pos_nxt = 5'd1;
      end else begin
        if (byte_pos_r < FRAME_BYTES) begin
          byte_pos_nxt = byte_pos_r + 5'd1;
        end
        if (take) begin
          if (held_sum < RAW_BITS) begin
            buf_nxt  = merged;
            held_nxt = held_sum;
          end else begin
            buf_nxt     = merged >> RAW_W;
            held_nxt    = held_sum - RAW_BITS;
            next_ch_nxt = next_ch_r + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      frame_ok_r <= 1'b0;
      buf_r      <= '0;
      held_r     <= '0;
      next_ch_r  <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      frame_ok_r <= frame_ok_nxt;
      buf_r      <= buf_nxt;
      held_r     <= held_nxt;
      next_ch_r  <= next_ch_nxt;
    end
  end

  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_ch_r <= NUM_CHANNELS)
    else $error("channel counter ran past the channel count");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= {1'b0, MAX_BITS_HELD})
    else $error("bit buffer holds a full channel that was not emitted");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && go && frame_first |=> byte_pos_r == 5'd1 && next_ch_r == 5'd0 && held_r == 5'd0)
    else $error("first byte did not restart the frame state");

endmodule

[hdl/sbd_center.sv]
// sbd_center: centers a raw channel and applies the deadband to the leading
// channels. Pure combinational; depends on sbd_pkg.
module sbd_center (
  input  logic                     [10:0] raw,
  input  logic                     [3:0]  chan,
  input  sbd_pkg::cfg_t                   cfg,
  output logic signed              [11:0] value
);
  import sbd_pkg::*;

  logic signed [11:0] diff;
  logic        [11:0] mag;
  logic               in_band;

  always_comb begin
    diff    = $signed({1'b0, raw}) - $signed({1'b0, cfg.center_value});
    mag     = diff[11] ? 12'(-diff) : 12'(diff);
    in_band = ({1'b0, chan} < cfg.deadband_channels) && (mag <= {1'b0, cfg.deadband});
    value   = in_band ? 12'sd0 : diff;
  end

endmodule

[hdl/sbus_channel_decoder.sv]
// sbus_channel_decoder: top level of the serial-bus frame channel decoder.
// Depends on sbd_pkg, sbd_unpack and sbd_center.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in_     | input     | in_valid / in_ready  | in_rx_byte[7:0], in_frame_first
//  out_    | output    | out_valid / out_ready| out_channel_number[3:0],
//          |           |                      | out_channel_value[11:0] (signed),
//          |           |                      | out_last_channel
//  cfg_    | input     | cfg_wr_en            | cfg_index[1:0], cfg_wdata[10:0]
//
// Cycles: one byte beat per clock while no completing byte waits. A beat lands
// in the input register, then unpacking and centering run combinationally into
// the result register, which raises out_valid when the completing byte moves
// on, unless a waiting result holds that byte back.
// Reset: synchronous, active low; clears frame state, both valid flags and
// restores the register defaults (center 1024, deadband 20, 4 channels).
// Stalls: a byte that completes no channel moves on even while a result
// waits; a byte that completes one holds in the input register until the
// result register frees up, and in_ready drops only then.
module sbus_channel_decoder (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_first,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_channel_number,
  output logic signed [11:0] out_channel_value,
  output logic               out_last_channel,

  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_wdata
);
  import sbd_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;

  // result register
  logic               out_valid_r;
  logic [3:0]         out_num_r;
  logic signed [11:0] out_val_r;
  logic               out_last_r;

  chan_res_t          res;
  logic signed [11:0] centered;
  logic               out_free;
  logic               s1_adv;

  // Take register writes at once; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_value      <= CENTER_RESET;
      cfg_r.deadband          <= DEADBAND_RESET;
      cfg_r.deadband_channels <= DB_CHAN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER:   cfg_r.center_value      <= cfg_wdata;
        CFG_DEADBAND: cfg_r.deadband          <= cfg_wdata;
        CFG_DB_CHANS: cfg_r.deadband_channels <= cfg_wdata[4:0];
        CFG_UNUSED:   ;
        default:      ;
      endcase
    end
  end

  // The input register advances when its byte either yields nothing or the
  // result register can take the new channel this edge.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!res.fire || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_rx_byte;
      s1_first_r <= in_frame_first;
    end
  end

  sbd_unpack u_unpack (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (s1_adv),
    .rx_byte     (s1_byte_r),
    .frame_first (s1_first_r),
    .res         (res)
  );

  sbd_center u_center (
    .raw   (res.raw),
    .chan  (res.chan),
    .cfg   (cfg_r),
    .value (centered)
  );

  // Result register: load on a completed channel, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.fire) begin
      out_num_r  <= res.chan;
      out_val_r  <= centered;
      out_last_r <= res.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_number = out_num_r;
  assign out_channel_value  = out_val_r;
  assign out_last_channel   = out_last_r;

  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a byte in the input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(s1_adv && res.fire))
    else $error("pending result would be overwritten");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty input register");

endmodule

[test/sbd_checker.sv]
// sbd_checker: watches the byte, result and register ports of the channel decoder,
// predicts each centered channel value and compares it with what comes out.
// Depends on sbd_pkg for the frame constants, register indexes and reset defaults.
`timescale 1ns / 100ps

module sbd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_first,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         out_channel_number,
  input  logic signed [11:0] out_channel_value,
  input  logic               out_last_channel,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 channels_seen
);
  import sbd_pkg::*;

  localparam int ERR_PRINT_MAX = 60;

  typedef struct packed {
    logic [3:0]         chan;
    logic signed [11:0] value;
    logic               last;
  } chan_beat_t;

  chan_beat_t chan_expect_q[$];

  // register copies
  logic [10:0] center;
  logic [10:0] deadband;
  logic [4:0]  db_chans;

  // frame unpacking state
  logic [4:0]  byte_pos;
  logic        frame_ok;
  logic [17:0] bit_buf;
  logic [4:0]  bits_held;
  logic [4:0]  next_chan;

  initial begin
    fail_count    = 0;
    pending       = 0;
    channels_seen = 0;
  end

  function automatic logic signed [11:0] centered(input logic [10:0] raw,
                                                  input logic [4:0] chan);
    int v;
    int mag;
    v   = int'(raw) - int'(center);
    mag = (v < 0) ? -v : v;
    if (chan < db_chans && mag <= int'(deadband)) v = 0;
    return v[11:0];
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    if (fail_count < ERR_PRINT_MAX)
      $error("%s: expected %0d, got %0d", field, want, got);
    fail_count++;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic first);
    logic [4:0] pos;
    chan_beat_t beat;
    if (first) begin
      frame_ok  = (b == SYNC_BYTE);
      bit_buf   = '0;
      bits_held = '0;
      next_chan = '0;
      byte_pos  = 5'd1;
    end else begin
      pos = byte_pos;
      if (byte_pos < FRAME_BYTES) byte_pos = byte_pos + 5'd1;
      if (frame_ok && pos != 0 && pos <= LAST_DATA_BYTE && next_chan < NUM_CHANNELS) begin
        bit_buf   = bit_buf | (18'(b) << bits_held[3:0]);
        bits_held = bits_held + BITS_PER_BYTE;
        if (bits_held >= RAW_BITS) begin
          beat.chan  = next_chan[3:0];
          beat.value = centered(bit_buf[10:0], next_chan);
          beat.last  = (next_chan == NUM_CHANNELS - 5'd1);
          chan_expect_q.push_back(beat);
          bit_buf   = bit_buf >> RAW_BITS;
          bits_held = bits_held - RAW_BITS;
          next_chan = next_chan + 5'd1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    chan_beat_t want;
    if (!rst_n) begin
      center    = CENTER_RESET;
      deadband  = DEADBAND_RESET;
      db_chans  = DB_CHAN_RESET;
      byte_pos  = '0;
      frame_ok  = 1'b0;
      bit_buf   = '0;
      bits_held = '0;
      next_chan = '0;
      chan_expect_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CENTER:   center   = cfg_wdata;
          CFG_DEADBAND: deadband = cfg_wdata;
          CFG_DB_CHANS: db_chans = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        channels_seen++;
        if (chan_expect_q.size() == 0) begin
          flag_field("unexpected channel_number", -1, int'(out_channel_number));
        end else begin
          want = chan_expect_q.pop_front();
          if (out_channel_number !== want.chan)
            flag_field("channel_number", int'(want.chan), int'(out_channel_number));
          if (out_channel_value !== want.value)
            flag_field("channel_value", int'(want.value), int'(out_channel_value));
          if (out_last_channel !== want.last)
            flag_field("last_channel", int'(want.last), int'(out_last_channel));
        end
      end
      if (in_valid && in_ready) take_byte(in_rx_byte, in_frame_first);
    end
    pending <= chan_expect_q.size();
  end

endmodule

[test/tb.sv]
// tb: stimulus and verdict for sbus_channel_decoder; sbd_checker does the prediction.
// Depends on sbd_pkg, sbd_checker and the decoder RTL under hdl/.
`timescale 1ns / 100ps

module tb;
  import sbd_pkg::*;

  localparam int LIMIT_CYCLES  = 300000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 6;     // byte register plus result register, with margin
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BYTES   = 250;
  localparam int CHANS         = int'(NUM_CHANNELS);

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte     = 8'h00;
  logic               in_frame_first = 1'b0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [3:0]         out_channel_number;
  logic signed [11:0] out_channel_value;
  logic               out_last_channel;
  logic               cfg_wr_en      = 1'b0;
  logic [1:0]         cfg_index      = CFG_CENTER;
  logic [10:0]        cfg_wdata      = 11'd0;

  int fail_count;
  int pending;
  int channels_seen;

  int cycle_cnt  = 0;
  int bytes_sent = 0;
  int idle_pct   = 0;   // sender: chance in a hundred to skip a cycle
  int stall_pct  = 0;   // receiver: chance in a hundred to drop ready
  int hold_asked = 0;
  int hold_done  = 0;
  int hold_left  = 0;
  int cur_center = int'(CENTER_RESET);
  int cur_db     = int'(DEADBAND_RESET);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  sbus_channel_decoder u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_frame_first     (in_frame_first),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel_number (out_channel_number),
    .out_channel_value  (out_channel_value),
    .out_last_channel   (out_last_channel),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  sbd_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .in_frame_first     (in_frame_first),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel_number (out_channel_number),
    .out_channel_value  (out_channel_value),
    .out_last_channel   (out_last_channel),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending            (pending),
    .channels_seen      (channels_seen)
  );

  // Receiver: a requested hold-off keeps ready low while hold_left counts down
  // here; otherwise ready follows the stall chance of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= stall_pct);
    end
  end

  // Watchdog: stop a hung run.
  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d channel values still owed", cycle_cnt, pending);
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one byte beat and hold it until accepted. Drop valid only when a gap
  // follows, so a back-to-back beat never sees valid lowered and raised in one step.
  task automatic send_beat(input logic [7:0] b, input logic first);
    while (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_first <= first;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send a frame of len bytes: the start byte, the 22 packed data bytes (channels
  // LSB first, 11 bits each), then flag/end bytes and any overrun as random bytes.
  // A len below 23 cuts the frame short.
  task automatic send_frame(input logic [7:0] start, input int len,
                            input logic [10:0] raws [CHANS]);
    logic [CHANS*11-1:0] packed_bits;
    for (int i = 0; i < CHANS; i++) packed_bits[i*11 +: 11] = raws[i];
    send_beat(start, 1'b1);
    for (int k = 1; k < len; k++) begin
      if (k <= int'(LAST_DATA_BYTE)) send_beat(packed_bits[(k-1)*8 +: 8], 1'b0);
      else                           send_beat(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // Raw channel values: mostly around the deadband edges of the current
  // setting, some at the ends of the 11-bit range, some anywhere.
  function automatic logic [10:0] pick_raw();
    int v;
    case ($urandom_range(7))
      0:       v = 0;
      1:       v = 2047;
      2, 3:    v = int'($urandom_range(2047));
      4:       v = cur_center + cur_db + int'($urandom_range(1));
      5:       v = cur_center - cur_db - int'($urandom_range(1));
      default: v = cur_center + int'($urandom_range(2 * cur_db + 2)) - cur_db - 1;
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[10:0];
  endfunction

  // Idle the sender until every owed channel has come out, then let any byte
  // that completes no channel clear the pipeline.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; pending != 0 && n < DRAIN_LIMIT; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers in one burst with the write enable held; the unused
  // index goes first and must change nothing.
  task automatic write_settings(input logic [10:0] center_w, input logic [10:0] db_w,
                                input logic [10:0] dbch_w);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 11'($urandom_range(2047));
    @(posedge clk);
    cfg_index <= CFG_CENTER;
    cfg_wdata <= center_w;
    @(posedge clk);
    cfg_index <= CFG_DEADBAND;
    cfg_wdata <= db_w;
    @(posedge clk);
    cfg_index <= CFG_DB_CHANS;
    cfg_wdata <= dbch_w;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cur_center = int'(center_w);
    cur_db     = int'(db_w);
  endtask

  initial begin
    logic [10:0] raws [CHANS];
    logic [7:0]  b;
    int          kind;
    int          len;
    int          phase_start;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values (center 1024, deadband 20, 4 channels).
    // Bytes before any frame start: ignored.
    send_beat(SYNC_BYTE, 1'b0);
    send_beat(8'hFF, 1'b0);
    // Frame with a wrong start byte: no channels.
    send_beat(SYNC_BYTE ^ 8'h01, 1'b1);
    send_beat(8'hA5, 1'b0);
    // Good frame: deadband edges on the deadband channels, range ends and
    // alternating bit patterns elsewhere; overrun bytes past the end byte.
    raws = '{11'd1004, 11'd1044, 11'd1045, 11'd1003, 11'd1024, 11'd0,    11'd2047, 11'd1025,
             11'h555,  11'h2AA,  11'h7FF,  11'h000,  11'h001,  11'h400,  11'h3FF,  11'h7FE};
    send_frame(SYNC_BYTE, 26, raws);
    drain_and_settle();

    // Random part: one register setting and one idling pattern per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       write_settings(CENTER_RESET, DEADBAND_RESET, 11'(DB_CHAN_RESET));
        1:       write_settings(11'd0, 11'd0, 11'd0);
        2:       write_settings(11'd2047, 11'd2047, 11'd16);
        3:       write_settings(11'($urandom_range(2047)), 11'($urandom_range(63)), 11'h7F3);
        4:       write_settings(11'd1024, 11'd100, 11'd16);
        5:       write_settings(11'd512, 11'd2047, 11'h7FF);
        6:       write_settings(11'($urandom_range(2047)), 11'($urandom_range(300)),
                                11'($urandom_range(16)));
        default: write_settings(11'd2047, 11'd0, 11'd1);
      endcase
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 56; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 56; end
        default: begin idle_pct = 22; stall_pct <= 22; end
      endcase
      // Hold the receiver off for a long stretch while bytes keep coming, so
      // the decoder backs up and drops in_ready.
      if (p == 2 || p == 5) hold_asked <= hold_asked + 1;

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        kind = int'($urandom_range(99));
        for (int i = 0; i < CHANS; i++) raws[i] = pick_raw();
        if (kind < 70) begin
          // well-formed frame, now and then short by a byte or two or overlong
          len = ($urandom_range(3) == 0) ? int'($urandom_range(23, 29)) : int'(FRAME_BYTES);
          send_frame(SYNC_BYTE, len, raws);
        end else if (kind < 80) begin
          b = 8'($urandom_range(255));
          if (b == SYNC_BYTE) b = b ^ 8'h80;
          send_frame(b, int'($urandom_range(2, 25)), raws);
        end else if (kind < 90) begin
          // cut frame: the next start byte arrives mid-frame and restarts it
          send_frame(SYNC_BYTE, int'($urandom_range(2, 22)), raws);
        end else begin
          repeat ($urandom_range(1, 6))
            send_beat(8'($urandom_range(255)), ($urandom_range(3) == 0));
        end
      end
      drain_and_settle();
    end

    for (int n = 0; pending != 0 && n < DRAIN_LIMIT; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d byte beats in %0d register settings, %0d channel values compared",
             bytes_sent, NUM_PHASES + 1, channels_seen);
    $display("frames good, cut, overlong and with bad start; stray bytes; two long hold-offs");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d channel values never came out", fail_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
